FILE: rtl/us2cal_pkg.sv
package us2cal_pkg;

    localparam int PC_W = 3;

    localparam logic [7:0]  OFFSET_RESET  = 8'd27;
    localparam logic [31:0] DAYS_TO_2000  = 32'd10957;
    localparam logic [31:0] DAYS_TO_2100  = 32'd47482;
    localparam logic [31:0] DAYS_4_YEARS  = 32'd1461;
    localparam logic [8:0]  DAYS_YEAR     = 9'd365;
    localparam logic [8:0]  DAYS_LEAP     = 9'd366;
    localparam logic [6:0]  LAST_YEAR     = 7'd99;
    localparam logic [3:0]  LAST_MONTH    = 4'd11;
    localparam logic [3:0]  FEBRUARY      = 4'd1;
    localparam logic [3:0]  TEN           = 4'd10;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [5:0]  HOURS_PER_DAY = 6'd24;
    localparam logic [31:0] RECIP_15      = 32'h8888_8889;
    localparam logic [31:0] RECIP_3       = 32'hAAAA_AAAB;

    typedef enum logic [2:0] {
        OP_DIV,
        OP_RANGE,
        OP_BLOCK,
        OP_YEAR,
        OP_MONTH,
        OP_DONE
    } t_op;

    typedef enum logic [1:0] {
        DST_SEC,
        DST_MIN,
        DST_HOUR
    } t_dest;

    typedef struct packed {
        t_op              op;
        logic [5:0]       divisor;
        t_dest            dest;
        logic [PC_W-1:0]  target;
    } t_uword;

    localparam logic [PC_W-1:0] PC_ONE  = 3'd1;
    localparam logic [PC_W-1:0] PC_DONE = 3'd7;

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{op: OP_DONE, divisor: 6'd1, dest: DST_SEC, target: PC_DONE};
        case (pc)
            3'd0: begin
                w = '{op: OP_DIV, divisor: SECS_PER_MIN, dest: DST_SEC, target: PC_DONE};
            end
            3'd1: begin
                w = '{op: OP_DIV, divisor: SECS_PER_MIN, dest: DST_MIN, target: PC_DONE};
            end
            3'd2: begin
                w = '{op: OP_DIV, divisor: HOURS_PER_DAY, dest: DST_HOUR, target: PC_DONE};
            end
            3'd3: begin
                w.op = OP_RANGE;
            end
            3'd4: begin
                w.op = OP_BLOCK;
            end
            3'd5: begin
                w.op = OP_YEAR;
            end
            3'd6: begin
                w.op = OP_MONTH;
            end
            default: begin
                w.op = OP_DONE;
            end
        endcase
        return w;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd1:    len = 5'd28;
            4'd3:    len = 5'd30;
            4'd5:    len = 5'd30;
            4'd8:    len = 5'd30;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/unix_seconds_to_calendar.sv
// Converts a count of seconds since 1970-01-01 into time of day and a date in 2000..2099.
// The offset register is subtracted first (saturating at zero). A small microcode program
// steps one shared datapath: three divisions by 60, 60 and 24 by reciprocal multiplication,
// a range check, a loop peeling 1461-day four-year blocks, single-year steps and month
// steps. The time from transfer in to result is set by the block, year and month loops,
// and by the output stall while a finished result waits; the input stalls while an item
// is in work, and a finished result waits in the output register while the next item is
// taken. Outside 2000..2099 out_of_range is set with date 00-01-01.
module unix_seconds_to_calendar (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_epoch_seconds,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [5:0]  o_second_of_minute,
    output logic [5:0]  o_minute_of_hour,
    output logic [4:0]  o_hour_of_day,
    output logic [6:0]  o_year_of_century,
    output logic [4:0]  o_month_bcd,
    output logic [4:0]  o_day_of_month,
    output logic        o_out_of_range
);

    logic [7:0]  r_offset;
    logic        r_busy, n_busy;
    logic [us2cal_pkg::PC_W-1:0] r_pc, n_pc;
    logic [31:0] r_acc, n_acc;
    logic [6:0]  r_year, n_year;
    logic [3:0]  r_month, n_month;
    logic        r_oor, n_oor;
    logic [5:0]  r_sec, n_sec;
    logic [5:0]  r_min, n_min;
    logic [4:0]  r_hour, n_hour;

    logic        r_out_valid, n_out_valid;
    logic [5:0]  r_o_sec, n_o_sec;
    logic [5:0]  r_o_min, n_o_min;
    logic [4:0]  r_o_hour, n_o_hour;
    logic [6:0]  r_o_year, n_o_year;
    logic [4:0]  r_o_month, n_o_month;
    logic [4:0]  r_o_day, n_o_day;
    logic        r_o_oor, n_o_oor;

    us2cal_pkg::t_uword cw;
    logic        div_by_min;
    logic [31:0] mul_a, mul_k, div_quo;
    logic [63:0] mul_p;
    logic [5:0]  rem60;
    logic [4:0]  rem24;
    logic [31:0] offset_ext, in_diff;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic [3:0]  month_num;
    logic        out_free;

    assign o_in_stall         = r_busy;
    assign o_out_valid        = r_out_valid;
    assign o_second_of_minute = r_o_sec;
    assign o_minute_of_hour   = r_o_min;
    assign o_hour_of_day      = r_o_hour;
    assign o_year_of_century  = r_o_year;
    assign o_month_bcd        = r_o_month;
    assign o_day_of_month     = r_o_day;
    assign o_out_of_range     = r_o_oor;

    always_comb begin
        cw         = us2cal_pkg::ucode(r_pc);
        div_by_min = (cw.divisor == us2cal_pkg::SECS_PER_MIN);
        mul_a      = div_by_min ? {2'b00, r_acc[31:2]} : {3'b000, r_acc[31:3]};
        mul_k      = div_by_min ? us2cal_pkg::RECIP_15 : us2cal_pkg::RECIP_3;
        mul_p      = {32'd0, mul_a} * {32'd0, mul_k};
        div_quo    = div_by_min ? {3'd0, mul_p[63:35]} : {1'b0, mul_p[63:33]};
        rem60      = r_acc[5:0] + {div_quo[3:0], 2'b00};
        rem24      = r_acc[4:0] + {div_quo[1:0], 3'b000};
        offset_ext = {24'd0, r_offset};
        in_diff    = (i_epoch_seconds >= offset_ext) ? (i_epoch_seconds - offset_ext) : 32'd0;
        ylen       = (r_year[1:0] == 2'd0) ? us2cal_pkg::DAYS_LEAP : us2cal_pkg::DAYS_YEAR;
        mlen       = us2cal_pkg::month_len(r_month)
                   + {4'd0, (r_month == us2cal_pkg::FEBRUARY) && (r_year[1:0] == 2'd0)};
        month_num  = r_month + 4'd1;
        out_free   = !r_out_valid || !i_out_stall;

        n_busy = r_busy;  n_pc = r_pc;    n_acc = r_acc;
        n_year = r_year;  n_month = r_month; n_oor = r_oor;
        n_sec = r_sec;    n_min = r_min;   n_hour = r_hour;
        n_out_valid = r_out_valid;
        n_o_sec = r_o_sec;   n_o_min = r_o_min;     n_o_hour = r_o_hour;
        n_o_year = r_o_year; n_o_month = r_o_month; n_o_day = r_o_day;
        n_o_oor = r_o_oor;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (!r_busy) begin
            if (i_in_valid) begin
                n_busy  = 1'b1;
                n_pc    = '0;
                n_acc   = in_diff;
                n_year  = '0;
                n_month = '0;
                n_oor   = 1'b0;
            end
        end else begin
            case (cw.op)
                us2cal_pkg::OP_DIV: begin
                    n_acc = div_quo;
                    n_pc  = r_pc + us2cal_pkg::PC_ONE;
                    case (cw.dest)
                        us2cal_pkg::DST_SEC:  n_sec  = rem60;
                        us2cal_pkg::DST_MIN:  n_min  = rem60;
                        us2cal_pkg::DST_HOUR: n_hour = rem24;
                        default:              n_sec  = r_sec;
                    endcase
                end
                us2cal_pkg::OP_RANGE: begin
                    if (r_acc < us2cal_pkg::DAYS_TO_2000 || r_acc >= us2cal_pkg::DAYS_TO_2100) begin
                        n_oor = 1'b1;
                        n_acc = '0;
                        n_pc  = cw.target;
                    end else begin
                        n_acc = r_acc - us2cal_pkg::DAYS_TO_2000;
                        n_pc  = r_pc + us2cal_pkg::PC_ONE;
                    end
                end
                us2cal_pkg::OP_BLOCK: begin
                    if (r_acc >= us2cal_pkg::DAYS_4_YEARS) begin
                        n_acc  = r_acc - us2cal_pkg::DAYS_4_YEARS;
                        n_year = r_year + 7'd4;
                    end else begin
                        n_pc = r_pc + us2cal_pkg::PC_ONE;
                    end
                end
                us2cal_pkg::OP_YEAR: begin
                    if (r_acc >= {23'd0, ylen} && r_year < us2cal_pkg::LAST_YEAR) begin
                        n_acc  = r_acc - {23'd0, ylen};
                        n_year = r_year + 7'd1;
                    end else begin
                        n_pc = r_pc + us2cal_pkg::PC_ONE;
                    end
                end
                us2cal_pkg::OP_MONTH: begin
                    if (r_month < us2cal_pkg::LAST_MONTH && r_acc >= {27'd0, mlen}) begin
                        n_acc   = r_acc - {27'd0, mlen};
                        n_month = r_month + 4'd1;
                    end else begin
                        n_pc = r_pc + us2cal_pkg::PC_ONE;
                    end
                end
                us2cal_pkg::OP_DONE: begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_o_sec     = r_sec;
                        n_o_min     = r_min;
                        n_o_hour    = r_hour;
                        n_o_year    = r_year;
                        n_o_month   = (month_num >= us2cal_pkg::TEN)
                                    ? {1'b1, month_num - us2cal_pkg::TEN}
                                    : {1'b0, month_num};
                        n_o_day     = r_acc[4:0] + 5'd1;
                        n_o_oor     = r_oor;
                        n_busy      = 1'b0;
                    end
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= us2cal_pkg::OFFSET_RESET;
            r_busy      <= 1'b0;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_offset <= i_cfg_wr_data;
            end
            r_busy      <= n_busy;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc     <= n_acc;
        r_year    <= n_year;
        r_month   <= n_month;
        r_oor     <= n_oor;
        r_sec     <= n_sec;
        r_min     <= n_min;
        r_hour    <= n_hour;
        r_o_sec   <= n_o_sec;
        r_o_min   <= n_o_min;
        r_o_hour  <= n_o_hour;
        r_o_year  <= n_o_year;
        r_o_month <= n_o_month;
        r_o_day   <= n_o_day;
        r_o_oor   <= n_o_oor;
    end

    a_start_at_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_busy && r_pc == '0))
        else $error("sequencer did not start at first step");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && cw.op == us2cal_pkg::OP_DIV)
        |-> (div_by_min ? (rem60 < us2cal_pkg::SECS_PER_MIN)
                        : ({1'b0, rem24} < us2cal_pkg::HOURS_PER_DAY)))
        else $error("division remainder out of span");

    a_month_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_month <= us2cal_pkg::LAST_MONTH && r_year <= us2cal_pkg::LAST_YEAR))
        else $error("month or year index out of span");

    a_date_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (o_day_of_month != 5'd0 && o_month_bcd != 5'd0
                                && o_hour_of_day < 5'd24 && o_minute_of_hour < 6'd60))
        else $error("result fields out of span");

endmodule

FILE: tb/tb_unix_seconds_to_calendar.sv
`timescale 1ns / 1ps

module tb_unix_seconds_to_calendar;

    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
        logic [6:0] year;
        logic [4:0] month;
        logic [4:0] day;
        logic       oor;
    } t_calendar;

    typedef struct packed {
        logic [31:0] secs;
        logic        typed;
        t_calendar   want;
    } t_row;

    localparam logic [31:0] Y2K_SECS    = 32'd946684800;
    localparam logic [31:0] Y2K_AT_RST  = 32'd946684827;
    localparam logic [31:0] SECS_DAY    = 32'd86400;
    localparam int unsigned DAYS_TO_Y2K = 10957;
    localparam int unsigned DAYS_CENT   = 36525;
    localparam int          PHASES      = 9;
    localparam int          PHASE_ITEMS = 44;

    localparam t_calendar EPOCH_START = '{6'd0, 6'd0, 5'd0, 7'd0, 5'h01, 5'd1, 1'b1};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [7:0]  i_cfg_wr_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [31:0] i_epoch_seconds;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [5:0]  o_second_of_minute;
    logic [5:0]  o_minute_of_hour;
    logic [4:0]  o_hour_of_day;
    logic [6:0]  o_year_of_century;
    logic [4:0]  o_month_bcd;
    logic [4:0]  o_day_of_month;
    logic        o_out_of_range;

    logic        tx_typed;
    t_calendar   tx_want;
    logic [7:0]  cfg_offset = us2cal_pkg::OFFSET_RESET;
    bit          tx_quiet;
    bit          rx_quiet;
    int          rx_hold_len;
    int          mismatches;
    t_calendar   calendar_q[$];

    t_row directed_rows [23] = '{
        '{32'd0,  1'b1, EPOCH_START},
        '{32'd26, 1'b1, EPOCH_START},
        '{32'd27, 1'b1, EPOCH_START},
        '{32'd28, 1'b1, '{6'd1, 6'd0, 5'd0, 7'd0, 5'h01, 5'd1, 1'b1}},
        '{Y2K_AT_RST - 32'd1, 1'b1, '{6'd59, 6'd59, 5'd23, 7'd0, 5'h01, 5'd1, 1'b1}},
        '{Y2K_AT_RST, 1'b1, '{6'd0, 6'd0, 5'd0, 7'd0, 5'h01, 5'd1, 1'b0}},
        '{Y2K_AT_RST + 32'd59 * SECS_DAY, 1'b0, '0},
        '{Y2K_AT_RST + 32'd60 * SECS_DAY, 1'b0, '0},
        '{Y2K_AT_RST + 32'd365 * SECS_DAY + 32'd86399, 1'b0, '0},
        '{Y2K_AT_RST + 32'd366 * SECS_DAY, 1'b0, '0},
        '{Y2K_AT_RST + 32'd424 * SECS_DAY, 1'b0, '0},
        '{Y2K_AT_RST + 32'd425 * SECS_DAY, 1'b0, '0},
        '{Y2K_AT_RST + 32'd1520 * SECS_DAY, 1'b0, '0},
        '{Y2K_AT_RST + 32'd1826 * SECS_DAY + 32'd43210, 1'b0, '0},
        '{Y2K_AT_RST + 32'd35123 * SECS_DAY, 1'b0, '0},
        '{Y2K_AT_RST + 32'd36160 * SECS_DAY, 1'b0, '0},
        '{Y2K_AT_RST + 32'd36494 * SECS_DAY, 1'b0, '0},
        '{32'd4102444826, 1'b1, '{6'd59, 6'd59, 5'd23, 7'd99, 5'h12, 5'd31, 1'b0}},
        '{32'd4102444827, 1'b1, '{6'd0, 6'd0, 5'd0, 7'd0, 5'h01, 5'd1, 1'b1}},
        '{32'hFFFF_FFFF, 1'b0, '0},
        '{32'h8000_0000, 1'b0, '0},
        '{32'h5555_5555, 1'b0, '0},
        '{32'hAAAA_AAAA, 1'b0, '0}
    };

    unix_seconds_to_calendar dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_epoch_seconds    (i_epoch_seconds),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_second_of_minute (o_second_of_minute),
        .o_minute_of_hour   (o_minute_of_hour),
        .o_hour_of_day      (o_hour_of_day),
        .o_year_of_century  (o_year_of_century),
        .o_month_bcd        (o_month_bcd),
        .o_day_of_month     (o_day_of_month),
        .o_out_of_range     (o_out_of_range)
    );

    function automatic bit is_leap(input int unsigned yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    function automatic t_calendar calendar_of(input logic [31:0] secs, input logic [7:0] offset);
        int unsigned month_days [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        t_calendar   c;
        logic [31:0] s;
        logic [31:0] mins;
        logic [31:0] hours;
        logic [31:0] days;
        int unsigned left;
        int unsigned yr;
        int unsigned yr_len;
        int unsigned mon;
        int unsigned mon_len;
        bit          leap;
        s     = (secs >= {24'd0, offset}) ? secs - {24'd0, offset} : 32'd0;
        mins  = s / 60;
        hours = mins / 60;
        days  = hours / 24;
        c.sec   = 6'(s % 60);
        c.min   = 6'(mins % 60);
        c.hour  = 5'(hours % 24);
        c.year  = 7'd0;
        c.month = 5'h01;
        c.day   = 5'd1;
        c.oor   = 1'b0;
        if (days < DAYS_TO_Y2K || days - DAYS_TO_Y2K >= DAYS_CENT) begin
            c.oor = 1'b1;
        end else begin
            left   = days - DAYS_TO_Y2K;
            yr     = 0;
            yr_len = 366;
            while (left >= yr_len && yr < 99) begin
                left   -= yr_len;
                yr++;
                yr_len = is_leap(yr + 2000) ? 366 : 365;
            end
            leap = is_leap(yr + 2000);
            mon  = 0;
            while (mon < 11) begin
                mon_len = month_days[mon] + ((mon == 1 && leap) ? 1 : 0);
                if (left < mon_len) break;
                left -= mon_len;
                mon++;
            end
            c.year  = 7'(yr);
            c.month = 5'((((mon + 1) / 10) << 4) | ((mon + 1) % 10));
            c.day   = 5'(left + 1);
        end
        return c;
    endfunction

    function automatic int pick_gap(input bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    function automatic logic [31:0] random_seconds();
        longint unsigned base;
        longint unsigned yr;
        int unsigned     pick;
        base = longint'(Y2K_SECS) + cfg_offset;
        pick = $urandom_range(0, 99);
        if (pick < 65) return 32'(base + $urandom_range(0, 32'd3155759999));
        if (pick < 80) begin
            yr = $urandom_range(0, 100);
            return 32'(base + (yr * 365 + (yr + 3) / 4) * 86400 + $urandom_range(0, 600) - 300);
        end
        if (pick < 90) return $urandom;
        return $urandom_range(0, 400);
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("%0t: %s mismatch: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic send_seconds(input logic [31:0] secs, input logic typed, input t_calendar want);
        int gap;
        gap = pick_gap(tx_quiet);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_epoch_seconds <= secs;
        tx_typed        <= typed;
        tx_want         <= want;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (calendar_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int len;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_len > 0) begin
                len         = rx_hold_len;
                rx_hold_len = 0;
                i_out_stall <= 1'b1;
                repeat (len) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                len = pick_gap(rx_quiet);
                i_out_stall <= (len != 0);
                if (len > 1) repeat (len - 1) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_calendar got;
        t_calendar want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = '{o_second_of_minute, o_minute_of_hour, o_hour_of_day, o_year_of_century,
                        o_month_bcd, o_day_of_month, o_out_of_range};
                if (calendar_q.size() == 0) begin
                    flag_mismatch("unrequested transfer", 1, 0);
                end else begin
                    want = calendar_q.pop_front();
                    if (got.sec != want.sec) flag_mismatch("second_of_minute", got.sec, want.sec);
                    if (got.min != want.min) flag_mismatch("minute_of_hour", got.min, want.min);
                    if (got.hour != want.hour) flag_mismatch("hour_of_day", got.hour, want.hour);
                    if (got.year != want.year) flag_mismatch("year_of_century", got.year, want.year);
                    if (got.month != want.month) flag_mismatch("month_bcd", got.month, want.month);
                    if (got.day != want.day) flag_mismatch("day_of_month", got.day, want.day);
                    if (got.oor != want.oor) flag_mismatch("out_of_range", got.oor, want.oor);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                calendar_q.push_back(tx_typed ? tx_want : calendar_of(i_epoch_seconds, cfg_offset));
            end
        end
    end

    initial begin
        int         phase;
        logic [7:0] offset;
        i_rst_n         <= 1'b0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_wr_data   <= 8'd0;
        i_in_valid      <= 1'b0;
        i_epoch_seconds <= 32'd0;
        tx_typed        <= 1'b0;
        tx_want         <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_seconds(directed_rows[i].secs, directed_rows[i].typed, directed_rows[i].want);
        end
        i_in_valid <= 1'b0;
        wait_drained();

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase == 0) offset = 8'd0;
            else if (phase == 1) offset = 8'd255;
            else if (phase == PHASES - 1) offset = us2cal_pkg::OFFSET_RESET;
            else offset = 8'($urandom_range(1, 254));
            i_cfg_wr_en   <= 1'b1;
            i_cfg_wr_data <= offset;
            @(posedge i_clk);
            i_cfg_wr_en <= 1'b0;
            cfg_offset = offset;

            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            if (phase == 2) begin
                tx_quiet    = 1'b1;
                rx_hold_len = 1500;
            end

            // saturation edge and the start of 2000 under this offset
            if (offset != 8'd0) send_seconds({24'd0, offset} - 32'd1, 1'b0, '0);
            send_seconds({24'd0, offset}, 1'b0, '0);
            send_seconds(Y2K_SECS + offset - 32'd1, 1'b0, '0);
            send_seconds(Y2K_SECS + offset, 1'b0, '0);
            repeat (PHASE_ITEMS) send_seconds(random_seconds(), 1'b0, '0);
            i_in_valid <= 1'b0;
            wait_drained();
            tx_quiet = 1'b0;
            rx_quiet = 1'b0;
        end

        repeat (200) @(posedge i_clk);
        if (calendar_q.size() != 0) flag_mismatch("outstanding results", calendar_q.size(), 0);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
